### hdl/bdtc_pkg.sv
// shared types and constants for the button debouncer and tap counter
`default_nettype none
package bdtc_pkg;

  localparam logic [1:0] OP_TICK       = 2'd0;
  localparam logic [1:0] OP_FORCE_DOWN = 2'd1;
  localparam logic [1:0] OP_FORCE_UP   = 2'd2;
  localparam logic [1:0] OP_QUIET      = 2'd3;

  localparam logic [2:0] PH_WAIT_PRESS   = 3'd0;
  localparam logic [2:0] PH_PRESS_STABLE = 3'd1;
  localparam logic [2:0] PH_HELD         = 3'd2;
  localparam logic [2:0] PH_REL_STABLE   = 3'd3;
  localparam logic [2:0] PH_QUIET        = 3'd4;

  localparam logic [16:0] TIMER17_MAX = 17'h1FFFF;
  localparam logic [31:0] HOLD_MAX    = 32'hFFFFFFFF;

  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] GAP_RST      = 16'd300;

  localparam logic [0:0] REG_DEBOUNCE = 1'b0;
  localparam logic [0:0] REG_GAP      = 1'b1;

  typedef struct packed {
    logic        down;
    logic        up;
    logic [31:0] rel_hold;
    logic        active;
    logic [31:0] cur_hold;
  } bdtc_ev_t;

  function automatic logic [16:0] add17(input logic [16:0] a, input logic [15:0] b);
    logic [17:0] s;
    s = {1'b0, a} + {2'b00, b};
    add17 = s[17] ? TIMER17_MAX : s[16:0];
  endfunction

endpackage
`default_nettype wire

### hdl/bdtc_cfg.sv
// apb configuration registers
`default_nettype none
module bdtc_cfg
  import bdtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      debounce_ms,
  output logic [15:0]      burst_gap_ms
);

  logic [15:0] debounce_r;
  logic [15:0] gap_r;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      gap_r      <= GAP_RST;
    end else if (wr) begin
      case (paddr[2])
        REG_DEBOUNCE: debounce_r <= pwdata[15:0];
        REG_GAP:      gap_r      <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEBOUNCE: prdata = {16'd0, debounce_r};
      REG_GAP:      prdata = {16'd0, gap_r};
      default:      prdata = 32'd0;
    endcase
  end

  assign debounce_ms  = debounce_r;
  assign burst_gap_ms = gap_r;

endmodule
`default_nettype wire

### hdl/bdtc_debounce.sv
// five-phase debouncer with saturating hold time
`default_nettype none
module bdtc_debounce
  import bdtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic [1:0]  op,
  input  wire logic        lvl,
  input  wire logic [15:0] dt,
  input  wire logic [15:0] debounce_ms,
  output bdtc_ev_t         ev
);

  logic [2:0]  phase_r, phase_nxt;
  logic [16:0] stable_r, stable_nxt;
  logic [31:0] hold_r, hold_nxt;
  logic [16:0] stable_add;
  logic [32:0] hold_add;
  logic        down, up;

  assign stable_add = add17(stable_r, dt);
  assign hold_add   = {1'b0, hold_r} + {17'd0, dt};

  always_comb begin
    phase_nxt  = phase_r;
    stable_nxt = stable_r;
    hold_nxt   = hold_r;
    down       = 1'b0;
    up         = 1'b0;
    case (op)
      OP_TICK: begin
        case (phase_r)
          PH_PRESS_STABLE: begin
            if (lvl) begin
              stable_nxt = stable_add;
              if (stable_add > {1'b0, debounce_ms}) begin
                phase_nxt = PH_HELD;
                hold_nxt  = {15'd0, stable_add};
                down      = 1'b1;
              end
            end else begin
              phase_nxt = PH_WAIT_PRESS;
            end
          end
          PH_HELD: begin
            if (lvl) begin
              hold_nxt = hold_add[32] ? HOLD_MAX : hold_add[31:0];
            end else begin
              phase_nxt  = PH_REL_STABLE;
              stable_nxt = 17'd0;
            end
          end
          PH_REL_STABLE, PH_QUIET: begin
            if (!lvl) begin
              stable_nxt = stable_add;
              if (stable_add > {1'b0, debounce_ms}) begin
                up        = (phase_r == PH_REL_STABLE);
                phase_nxt = PH_WAIT_PRESS;
              end
            end else begin
              stable_nxt = 17'd0;
            end
          end
          default: begin
            phase_nxt = PH_WAIT_PRESS;
            if (lvl) begin
              phase_nxt  = PH_PRESS_STABLE;
              stable_nxt = 17'd0;
            end
          end
        endcase
      end
      OP_FORCE_DOWN: begin
        phase_nxt = PH_HELD;
        hold_nxt  = 32'd0;
        down      = 1'b1;
      end
      OP_FORCE_UP: begin
        phase_nxt = PH_WAIT_PRESS;
        up        = 1'b1;
      end
      default: begin
        phase_nxt = PH_QUIET;
        hold_nxt  = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT_PRESS;
      stable_r <= 17'd0;
      hold_r   <= 32'd0;
    end else if (en) begin
      phase_r  <= phase_nxt;
      stable_r <= stable_nxt;
      hold_r   <= hold_nxt;
    end
  end

  always_comb begin
    ev.down     = down;
    ev.up       = up;
    ev.rel_hold = up ? hold_nxt : 32'd0;
    ev.active   = (phase_nxt == PH_HELD);
    ev.cur_hold = (phase_nxt == PH_HELD) ? hold_nxt : 32'd0;
  end

endmodule
`default_nettype wire

### hdl/bdtc_tap.sv
// tap burst counter with gap window
`default_nettype none
module bdtc_tap
  import bdtc_pkg::*;
#(
  parameter int TW = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        tick,
  input  wire logic        rel_nz,
  input  wire logic [15:0] dt,
  input  wire logic [15:0] burst_gap_ms,
  output logic [7:0]       tap_count
);

  localparam int EW = TW + 8;

  logic          counting_r, counting_nxt;
  logic [TW-1:0] taps_r, taps_nxt;
  logic [16:0]   gap_r, gap_nxt;
  logic [16:0]   gap_add;
  logic [EW-1:0] taps_ext;
  logic          burst_end;

  assign gap_add  = add17(gap_r, dt);
  assign taps_ext = EW'(taps_r);

  always_comb begin
    counting_nxt = counting_r;
    taps_nxt     = taps_r;
    gap_nxt      = gap_r;
    burst_end    = 1'b0;
    if (!counting_r) begin
      if (rel_nz) begin
        taps_nxt     = TW'(1);
        gap_nxt      = 17'd0;
        counting_nxt = 1'b1;
      end
    end else if (rel_nz) begin
      if (taps_r != {TW{1'b1}}) taps_nxt = taps_r + TW'(1);
      gap_nxt = 17'd0;
    end else if (tick) begin
      gap_nxt = gap_add;
      if (gap_add > {1'b0, burst_gap_ms}) begin
        burst_end    = 1'b1;
        taps_nxt     = '0;
        counting_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    tap_count = 8'd0;
    if (burst_end) begin
      tap_count = (taps_ext > EW'(255)) ? 8'd255 : taps_ext[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counting_r <= 1'b0;
      taps_r     <= '0;
      gap_r      <= 17'd0;
    end else if (en) begin
      counting_r <= counting_nxt;
      taps_r     <= taps_nxt;
      gap_r      <= gap_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/button_debounce_tap_counter.sv
// top level: input register, debouncer and tap counter, result register
// Every item (tick or command) yields exactly one result item. An accepted item
// sits in the input register until the result side can take it, passes through
// the debouncer and tap counter logic, and lands in the result register as it
// leaves the input register. A new item is taken every cycle as long as the
// result side keeps taking items; in_tready only drops when both the input and
// result registers are full and out_tready is low. The state of the debouncer
// and tap counter moves forward when the item leaves the input register.
// debounce_ms sits at byte address 0 and burst_gap_ms at byte address 4; both
// are 16 bits wide and should be written only while no item is in flight.
`default_nettype none
module button_debounce_tap_counter
  import bdtc_pkg::*;
#(
  parameter int TAP_COUNT_WIDTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // pressed, elapsed_ms
  input  wire logic [1:0]  in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // down_event, up_event, released_hold_ms, active, current_hold_ms, tap_count
  output logic [79:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic        s1_valid_r;
  logic [1:0]  s1_op_r;
  logic        s1_lvl_r;
  logic [15:0] s1_dt_r;
  logic        s1_adv;
  logic        out_valid_r;
  logic [74:0] out_data_r;
  logic [15:0] debounce_ms;
  logic [15:0] burst_gap_ms;
  bdtc_ev_t    ev;
  logic [7:0]  tap_count;

  bdtc_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .debounce_ms  (debounce_ms),
    .burst_gap_ms (burst_gap_ms)
  );

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r  <= in_tuser;
      s1_lvl_r <= in_tdata[0];
      s1_dt_r  <= in_tdata[16:1];
    end
  end

  bdtc_debounce u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (s1_adv),
    .op          (s1_op_r),
    .lvl         (s1_lvl_r),
    .dt          (s1_dt_r),
    .debounce_ms (debounce_ms),
    .ev          (ev)
  );

  bdtc_tap #(
    .TW (TAP_COUNT_WIDTH)
  ) u_tap (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (s1_adv),
    .tick         (s1_op_r == OP_TICK),
    .rel_nz       (ev.rel_hold != 32'd0),
    .dt           (s1_dt_r),
    .burst_gap_ms (burst_gap_ms),
    .tap_count    (tap_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {tap_count, ev.cur_hold, ev.active, ev.rel_hold, ev.up, ev.down};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};

endmodule
`default_nettype wire
